// ===== rtl/eqc_pkg.sv =====
// eqc_pkg: shared types, widths and constants of the attitude converter
// depends on nothing; used by every module of the block

package eqc_pkg;

	// default and upper bound of cordic iterations
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int MAX_STEPS = 30;

	// internal widths
	localparam int XW = 38;        // cordic x/y lanes
	localparam int ZW = 29;        // q.24 angle accumulator
	localparam int VW = 34;        // q.28 vector components
	localparam int SW = 30;        // clamped asin argument
	localparam int RW = 58;        // square root remainder and root
	localparam int ISQ_STEPS = 29; // one root bit per stage
	localparam int CW = 27;        // sine / cosine q.24
	localparam int MW = 28;        // first product
	localparam int PW = 32;        // second product and sums

	localparam logic signed [ZW-1:0] PI_Q24 = 29'sd52707179;
	localparam logic signed [ZW-1:0] HALF_PI_Q24 = 29'sd26353589;
	localparam logic signed [XW-1:0] GAIN_Q24 = 38'sd10188014;
	localparam logic signed [VW-1:0] ONE_Q28 = 34'sd268435456;
	localparam int RND_Q24 = 8388608;

	// arctangent of 2^-i in q.24, rounded to nearest
	localparam logic [25:0] ATAN_TBL [MAX_STEPS] = '{
		26'd13176795, 26'd7778716, 26'd4110060, 26'd2086331, 26'd1047214,
		26'd524117, 26'd262123, 26'd131069, 26'd65536, 26'd32768,
		26'd16384, 26'd8192, 26'd4096, 26'd2048, 26'd1024,
		26'd512, 26'd256, 26'd128, 26'd64, 26'd32,
		26'd16, 26'd8, 26'd4, 26'd2, 26'd1,
		26'd0, 26'd0, 26'd0, 26'd0, 26'd0
	};

	// conversion direction
	typedef enum logic {
		REQ_EUL2QUAT = 1'b0,
		REQ_QUAT2EUL = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] roll_in;
		logic signed [15:0] pitch_in;
		logic signed [15:0] yaw_in;
		logic signed [15:0] quat_w_in;
		logic signed [15:0] quat_x_in;
		logic signed [15:0] quat_y_in;
		logic signed [15:0] quat_z_in;
	} eqc_req_t;

	typedef struct packed {
		logic signed [15:0] roll_out;
		logic signed [15:0] pitch_out;
		logic signed [15:0] yaw_out;
		logic signed [15:0] quat_w_out;
		logic signed [15:0] quat_x_out;
		logic signed [15:0] quat_y_out;
		logic signed [15:0] quat_z_out;
		logic               asin_clamped;
	} eqc_rsp_t;

	// sideband carried through the square root pipeline
	typedef struct packed {
		eqc_req_t               req;
		logic                   clamp;
		logic [2:0]             neg;
		logic signed [ZW-1:0]   rz0;
		logic signed [ZW-1:0]   rz1;
		logic signed [ZW-1:0]   rz2;
		logic signed [VW-1:0]   ry;
		logic signed [VW-1:0]   rx;
		logic signed [VW-1:0]   yy;
		logic signed [VW-1:0]   yx;
		logic signed [SW-1:0]   s;
	} isq_side_t;

	// sideband carried through cordic and back end
	typedef struct packed {
		eqc_req_t   req;
		logic       clamp;
		logic [2:0] neg;
		logic [2:0] zero;
	} crd_side_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} lane_t;

endpackage

// ===== rtl/euler_quaternion_converter_unit.sv =====
// euler_quaternion_converter_unit: top level of the zyx euler / quaternion converter
// depends on eqc_pkg, eqc_front, eqc_isqrt, eqc_cordic, eqc_back

// Converts roll/pitch/yaw (Q2.13 rad, ZYX order) to a quaternion (Q1.14) or back,
// chosen per request by req_type; the side not converted is passed through. A fully
// pipelined design: one request is accepted every cycle unless the result side stalls.
// Each request passes three front stages for products and the radicand, 29
// square-root stages, one cordic setup stage plus one stage per cordic iteration,
// and three stages of product sums and rounding.
// A stall on the result side holds the whole pipeline, so req_stall follows
// rsp_valid && rsp_stall.

module euler_quaternion_converter_unit #(
	parameter int CORDIC_STEPS = eqc_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  eqc_pkg::eqc_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output eqc_pkg::eqc_rsp_t rsp_data
);
	import eqc_pkg::*;

	logic ce;
	logic f_v, i_v, c_v;
	isq_side_t f_side, i_side;
	logic [RW-1:0] f_rad;
	logic [SW-2:0] i_root;
	crd_side_t c_side;
	lane_t c_lanes [3];

	// whole pipeline advances unless the result register is held
	assign ce = !(rsp_valid && rsp_stall);
	assign req_stall = !ce;

	eqc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.ce     (ce),
		.in_v   (req_valid),
		.req    (req_data),
		.out_v  (f_v),
		.side   (f_side),
		.rad    (f_rad)
	);

	eqc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_v     (f_v),
		.in_side  (f_side),
		.rad      (f_rad),
		.out_v    (i_v),
		.out_side (i_side),
		.root     (i_root)
	);

	eqc_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_v     (i_v),
		.in_side  (i_side),
		.root     (i_root),
		.out_v    (c_v),
		.out_side (c_side),
		.lanes    (c_lanes)
	);

	eqc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.ce     (ce),
		.in_v   (c_v),
		.side   (c_side),
		.lanes  (c_lanes),
		.out_v  (rsp_valid),
		.rsp    (rsp_data)
	);

endmodule

// ===== rtl/eqc_front.sv =====
// eqc_front: input products, half-angle reduction, vector forming and radicand
// depends on eqc_pkg

module eqc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ce,
	input  logic              in_v,
	input  eqc_pkg::eqc_req_t req,
	output logic              out_v,
	output eqc_pkg::isq_side_t side,
	output logic [eqc_pkg::RW-1:0] rad
);
	import eqc_pkg::*;

	// half angle in q.24, folded into +-pi/2 with a sign flag
	function automatic logic [ZW:0] half_reduce(input logic signed [15:0] a);
		logic signed [ZW-1:0] th;
		th = {{(ZW-26){a[15]}}, a, 10'b0};
		if (th > HALF_PI_Q24)
			return {1'b1, th - PI_Q24};
		else if (th < -HALF_PI_Q24)
			return {1'b1, th + PI_Q24};
		return {1'b0, th};
	endfunction

	logic v_s1, v_s2, v_s3;
	eqc_req_t req_s1;
	logic signed [31:0] pwx_s1, pyz_s1, pxx_s1, pyy_s1, pwz_s1;
	logic signed [31:0] pxy_s1, pzz_s1, pwy_s1, pxz_s1;
	logic [ZW:0] r0_s1, r1_s1, r2_s1;
	isq_side_t side_s2, side_s3, side_nx2;
	logic [RW-1:0] rad_s3;
	logic signed [VW-1:0] sraw;
	logic signed [2*SW-1:0] sq;
	logic signed [2*SW-1:0] rad_full;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: products of quaternion parts and reduced half angles
	always_ff @(posedge clk) begin
		if (ce) begin
			req_s1 <= req;
			pwx_s1 <= req.quat_w_in * req.quat_x_in;
			pyz_s1 <= req.quat_y_in * req.quat_z_in;
			pxx_s1 <= req.quat_x_in * req.quat_x_in;
			pyy_s1 <= req.quat_y_in * req.quat_y_in;
			pwz_s1 <= req.quat_w_in * req.quat_z_in;
			pxy_s1 <= req.quat_x_in * req.quat_y_in;
			pzz_s1 <= req.quat_z_in * req.quat_z_in;
			pwy_s1 <= req.quat_w_in * req.quat_y_in;
			pxz_s1 <= req.quat_x_in * req.quat_z_in;
			r0_s1 <= half_reduce(req.roll_in);
			r1_s1 <= half_reduce(req.pitch_in);
			r2_s1 <= half_reduce(req.yaw_in);
		end
	end

	// stage 2: atan2 vectors and clamped asin argument in q.28
	always_comb begin
		side_nx2.req = req_s1;
		side_nx2.neg = {r2_s1[ZW], r1_s1[ZW], r0_s1[ZW]};
		side_nx2.rz0 = r0_s1[ZW-1:0];
		side_nx2.rz1 = r1_s1[ZW-1:0];
		side_nx2.rz2 = r2_s1[ZW-1:0];
		side_nx2.ry = (VW'(pwx_s1) + VW'(pyz_s1)) <<< 1;
		side_nx2.rx = ONE_Q28 - ((VW'(pxx_s1) + VW'(pyy_s1)) <<< 1);
		side_nx2.yy = (VW'(pwz_s1) + VW'(pxy_s1)) <<< 1;
		side_nx2.yx = ONE_Q28 - ((VW'(pzz_s1) + VW'(pyy_s1)) <<< 1);
		sraw = (VW'(pwy_s1) - VW'(pxz_s1)) <<< 1;
		side_nx2.clamp = 1'b0;
		side_nx2.s = sraw[SW-1:0];
		if (sraw > ONE_Q28) begin
			side_nx2.clamp = 1'b1;
			side_nx2.s = ONE_Q28[SW-1:0];
		end else if (sraw < -ONE_Q28) begin
			side_nx2.clamp = 1'b1;
			side_nx2.s = SW'(-ONE_Q28);
		end
	end

	always_ff @(posedge clk) begin
		if (ce)
			side_s2 <= side_nx2;
	end

	// stage 3: radicand 1 - s*s in q.56
	assign sq = side_s2.s * side_s2.s;
	assign rad_full = ((2*SW)'(1) <<< 56) - sq;

	always_ff @(posedge clk) begin
		if (ce) begin
			side_s3 <= side_s2;
			rad_s3 <= rad_full[RW-1:0];
		end
	end

	assign out_v = v_s3;
	assign side = side_s3;
	assign rad = rad_s3;

endmodule

// ===== rtl/eqc_isqrt.sv =====
// eqc_isqrt: pipelined integer square root, one root bit per stage
// depends on eqc_pkg

module eqc_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ce,
	input  logic               in_v,
	input  eqc_pkg::isq_side_t in_side,
	input  logic [eqc_pkg::RW-1:0] rad,
	output logic               out_v,
	output eqc_pkg::isq_side_t out_side,
	output logic [eqc_pkg::SW-2:0] root
);
	import eqc_pkg::*;

	logic      v_sk    [ISQ_STEPS];
	isq_side_t side_sk [ISQ_STEPS];
	logic [RW-1:0] rem_sk  [ISQ_STEPS];
	logic [RW-1:0] root_sk [ISQ_STEPS];

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_bit
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ISQ_STEPS - 1 - k));
		logic          v_in;
		isq_side_t     s_in;
		logic [RW-1:0] rem_in, root_in, trial, rem_nx, root_nx;

		if (k == 0) begin : g_first
			assign v_in = in_v;
			assign s_in = in_side;
			assign rem_in = rad;
			assign root_in = '0;
		end else begin : g_next
			assign v_in = v_sk[k-1];
			assign s_in = side_sk[k-1];
			assign rem_in = rem_sk[k-1];
			assign root_in = root_sk[k-1];
		end

		// restoring step against root + bit
		always_comb begin
			trial = root_in + BIT;
			if (rem_in >= trial) begin
				rem_nx = rem_in - trial;
				root_nx = (root_in >> 1) + BIT;
			end else begin
				rem_nx = rem_in;
				root_nx = root_in >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sk[k] <= 1'b0;
			else if (ce)
				v_sk[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				side_sk[k] <= s_in;
				rem_sk[k] <= rem_nx;
				root_sk[k] <= root_nx;
			end
		end
	end

	assign out_v = v_sk[ISQ_STEPS-1];
	assign out_side = side_sk[ISQ_STEPS-1];
	assign root = root_sk[ISQ_STEPS-1][SW-2:0];

endmodule

// ===== rtl/eqc_cordic.sv =====
// eqc_cordic: three cordic lanes, rotation or vectoring per request
// depends on eqc_pkg

module eqc_cordic #(
	parameter int STEPS = eqc_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ce,
	input  logic               in_v,
	input  eqc_pkg::isq_side_t in_side,
	input  logic [eqc_pkg::SW-2:0] root,
	output logic               out_v,
	output eqc_pkg::crd_side_t out_side,
	output eqc_pkg::lane_t     lanes [3]
);
	import eqc_pkg::*;

	// vectoring start: fold left half plane, start angle +-pi
	function automatic lane_t vec_init(input logic signed [XW-1:0] vx,
		input logic signed [XW-1:0] vy);
		lane_t l;
		if (vx < 0) begin
			l.x = -vx;
			l.y = -vy;
			l.z = (vy >= 0) ? PI_Q24 : -PI_Q24;
		end else begin
			l.x = vx;
			l.y = vy;
			l.z = '0;
		end
		return l;
	endfunction

	function automatic lane_t rot_init(input logic signed [ZW-1:0] z);
		lane_t l;
		l.x = GAIN_Q24;
		l.y = '0;
		l.z = z;
		return l;
	endfunction

	logic      v_sk    [STEPS+1];
	crd_side_t side_sk [STEPS+1];
	lane_t     lane_sk [STEPS+1][3];

	crd_side_t side_nx;
	lane_t     init_nx [3];
	logic signed [XW-1:0] vx [3];
	logic signed [XW-1:0] vy [3];

	// lane start values
	always_comb begin
		vx[0] = XW'(in_side.rx);
		vy[0] = XW'(in_side.ry);
		vx[1] = XW'($signed({1'b0, root}));
		vy[1] = XW'(in_side.s);
		vx[2] = XW'(in_side.yx);
		vy[2] = XW'(in_side.yy);
		side_nx.req = in_side.req;
		side_nx.clamp = in_side.clamp;
		side_nx.neg = in_side.neg;
		for (int j = 0; j < 3; j++)
			side_nx.zero[j] = (vx[j] == '0) && (vy[j] == '0);
		if (in_side.req.req_type == REQ_QUAT2EUL) begin
			for (int j = 0; j < 3; j++)
				init_nx[j] = vec_init(vx[j], vy[j]);
		end else begin
			init_nx[0] = rot_init(in_side.rz0);
			init_nx[1] = rot_init(in_side.rz1);
			init_nx[2] = rot_init(in_side.rz2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sk[0] <= 1'b0;
		else if (ce)
			v_sk[0] <= in_v;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			side_sk[0] <= side_nx;
			for (int j = 0; j < 3; j++)
				lane_sk[0][j] <= init_nx[j];
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [ZW-1:0] ATN = $signed({{(ZW-26){1'b0}}, ATAN_TBL[i]});
		lane_t nxt [3];

		always_comb begin
			lane_t l;
			logic  dn;
			for (int j = 0; j < 3; j++) begin
				l = lane_sk[i][j];
				if (side_sk[i].req.req_type == REQ_EUL2QUAT)
					dn = !l.z[ZW-1];
				else
					dn = l.y[XW-1];
				if (dn) begin
					nxt[j].x = l.x - (l.y >>> i);
					nxt[j].y = l.y + (l.x >>> i);
					nxt[j].z = l.z - ATN;
				end else begin
					nxt[j].x = l.x + (l.y >>> i);
					nxt[j].y = l.y - (l.x >>> i);
					nxt[j].z = l.z + ATN;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sk[i+1] <= 1'b0;
			else if (ce)
				v_sk[i+1] <= v_sk[i];
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				side_sk[i+1] <= side_sk[i];
				for (int j = 0; j < 3; j++)
					lane_sk[i+1][j] <= nxt[j];
			end
		end
	end

	assign out_v = v_sk[STEPS];
	assign out_side = side_sk[STEPS];
	assign lanes[0] = lane_sk[STEPS][0];
	assign lanes[1] = lane_sk[STEPS][1];
	assign lanes[2] = lane_sk[STEPS][2];

endmodule

// ===== rtl/eqc_back.sv =====
// eqc_back: quaternion product sums, angle rounding and result register
// depends on eqc_pkg

module eqc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ce,
	input  logic               in_v,
	input  eqc_pkg::crd_side_t side,
	input  eqc_pkg::lane_t     lanes [3],
	output logic               out_v,
	output eqc_pkg::eqc_rsp_t  rsp
);
	import eqc_pkg::*;

	function automatic logic signed [MW-1:0] mul_a(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = a * b;
		p = p + (2*CW)'(RND_Q24);
		return p[24 +: MW];
	endfunction

	function automatic logic signed [PW-1:0] mul_b(input logic signed [MW-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [MW+CW:0] p;
		p = a * b;
		p = p + (MW+CW+1)'(RND_Q24);
		return p[24 +: PW];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
		if (v > PW'(32767))
			return 16'sh7fff;
		if (v < -PW'(32768))
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] angle_rnd(input logic signed [ZW-1:0] z);
		logic signed [PW-1:0] t;
		t = (PW'(z) + PW'(1024)) >>> 11;
		return sat16(t);
	endfunction

	function automatic logic signed [15:0] quat_rnd(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		t = (v + PW'(512)) >>> 10;
		return sat16(t);
	endfunction

	logic v_s1, v_s2, v_s3;
	crd_side_t side_s1, side_s2;
	logic signed [CW-1:0] sn [3];
	logic signed [CW-1:0] cs [3];
	logic signed [MW-1:0] cycr_s1, sysr_s1, cysr_s1, sycr_s1;
	logic signed [CW-1:0] sp_s1, cp_s1;
	logic signed [15:0] ang_s1 [3];
	logic signed [15:0] ang_s2 [3];
	logic signed [PW-1:0] a_s2, b_s2, c_s2, d_s2, e_s2, f_s2, g_s2, h_s2;
	eqc_rsp_t rsp_s3, rsp_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// sine and cosine with half-turn correction
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sn[j] = side.neg[j] ? -lanes[j].y[CW-1:0] : lanes[j].y[CW-1:0];
			cs[j] = side.neg[j] ? -lanes[j].x[CW-1:0] : lanes[j].x[CW-1:0];
		end
	end

	// stage 1: yaw/roll cross products and rounded angles
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s1 <= side;
			cycr_s1 <= mul_a(cs[2], cs[0]);
			sysr_s1 <= mul_a(sn[2], sn[0]);
			cysr_s1 <= mul_a(cs[2], sn[0]);
			sycr_s1 <= mul_a(sn[2], cs[0]);
			sp_s1 <= sn[1];
			cp_s1 <= cs[1];
			for (int j = 0; j < 3; j++)
				ang_s1[j] <= side.zero[j] ? 16'sd0 : angle_rnd(lanes[j].z);
		end
	end

	// stage 2: products with pitch terms
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s2 <= side_s1;
			ang_s2 <= ang_s1;
			a_s2 <= mul_b(cycr_s1, cp_s1);
			b_s2 <= mul_b(sysr_s1, sp_s1);
			c_s2 <= mul_b(cysr_s1, cp_s1);
			d_s2 <= mul_b(sycr_s1, sp_s1);
			e_s2 <= mul_b(cycr_s1, sp_s1);
			f_s2 <= mul_b(sysr_s1, cp_s1);
			g_s2 <= mul_b(sycr_s1, cp_s1);
			h_s2 <= mul_b(cysr_s1, sp_s1);
		end
	end

	// stage 3: pick computed or passed-through fields
	always_comb begin
		rsp_nx.roll_out = side_s2.req.roll_in;
		rsp_nx.pitch_out = side_s2.req.pitch_in;
		rsp_nx.yaw_out = side_s2.req.yaw_in;
		rsp_nx.quat_w_out = side_s2.req.quat_w_in;
		rsp_nx.quat_x_out = side_s2.req.quat_x_in;
		rsp_nx.quat_y_out = side_s2.req.quat_y_in;
		rsp_nx.quat_z_out = side_s2.req.quat_z_in;
		rsp_nx.asin_clamped = 1'b0;
		if (side_s2.req.req_type == REQ_EUL2QUAT) begin
			rsp_nx.quat_w_out = quat_rnd(a_s2 + b_s2);
			rsp_nx.quat_x_out = quat_rnd(c_s2 - d_s2);
			rsp_nx.quat_y_out = quat_rnd(e_s2 + f_s2);
			rsp_nx.quat_z_out = quat_rnd(g_s2 - h_s2);
		end else begin
			rsp_nx.roll_out = ang_s2[0];
			rsp_nx.pitch_out = ang_s2[1];
			rsp_nx.yaw_out = ang_s2[2];
			rsp_nx.asin_clamped = side_s2.clamp;
		end
	end

	always_ff @(posedge clk) begin
		if (ce)
			rsp_s3 <= rsp_nx;
	end

	assign out_v = v_s3;
	assign rsp = rsp_s3;

endmodule

// ===== rtl/eqc_checker.sv =====
// eqc_checker: port-level assertions for the converter, bound to the top level
// depends on eqc_pkg and euler_quaternion_converter_unit

module eqc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input eqc_pkg::eqc_req_t req_data,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input eqc_pkg::eqc_rsp_t rsp_data
);

	// a held result stays valid and unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// request side blocks exactly when the result is held
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall == (rsp_valid && rsp_stall))
		else $error("request stall does not follow result stall");

	// a clamped asin argument yields pitch near +-pi/2
	a_clamp_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.asin_clamped |->
		rsp_data.pitch_out > 16'sd12000 || rsp_data.pitch_out < -16'sd12000)
		else $error("clamped request with small pitch");

	// an accepted request is not lost behind a held result
	a_no_accept_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |-> !(rsp_valid && rsp_stall))
		else $error("request taken while pipeline held");

endmodule

bind euler_quaternion_converter_unit eqc_checker u_eqc_checker (.*);
